FILE: sv/b2r_pkg.sv
// Shared types, letter codes and microcode table for the Roman numeral encoder.
package b2r_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned LETTER_W = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned STEP_W   = 2;
    localparam int unsigned PLACE_W  = 2;
    localparam int unsigned UADDR_W  = DIGIT_W + STEP_W;
    localparam int unsigned WIDE_W   = 14;
    localparam int unsigned LIMIT    = 4000;

    localparam logic [LETTER_W-1:0] CH_NONE = 8'h00;
    localparam logic [LETTER_W-1:0] CH_I    = 8'h49;
    localparam logic [LETTER_W-1:0] CH_V    = 8'h56;
    localparam logic [LETTER_W-1:0] CH_X    = 8'h58;
    localparam logic [LETTER_W-1:0] CH_L    = 8'h4C;
    localparam logic [LETTER_W-1:0] CH_C    = 8'h43;
    localparam logic [LETTER_W-1:0] CH_D    = 8'h44;
    localparam logic [LETTER_W-1:0] CH_M    = 8'h4D;

    localparam logic [PLACE_W-1:0] PL_UNITS     = 2'd0;
    localparam logic [PLACE_W-1:0] PL_TENS      = 2'd1;
    localparam logic [PLACE_W-1:0] PL_HUNDREDS  = 2'd2;
    localparam logic [PLACE_W-1:0] PL_THOUSANDS = 2'd3;

    typedef enum logic [1:0] {
        SYM_NONE,
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } t_sym;

    typedef struct packed {
        t_sym sym;
        logic fin;
    } t_uword;

    function automatic t_uword uw(input t_sym s, input logic f);
        t_uword w;
        w.sym = s;
        w.fin = f;
        return w;
    endfunction

    // Program: four steps per digit, address is {digit, step}
    function automatic t_uword ucode_rom(input logic [UADDR_W-1:0] addr);
        t_uword w;
        w = uw(SYM_NONE, 1'b1);
        case (addr)
            6'd0:  w = uw(SYM_NONE, 1'b1);
            6'd4:  w = uw(SYM_ONE,  1'b1);
            6'd8:  w = uw(SYM_ONE,  1'b0);
            6'd9:  w = uw(SYM_ONE,  1'b1);
            6'd12: w = uw(SYM_ONE,  1'b0);
            6'd13: w = uw(SYM_ONE,  1'b0);
            6'd14: w = uw(SYM_ONE,  1'b1);
            6'd16: w = uw(SYM_ONE,  1'b0);
            6'd17: w = uw(SYM_FIVE, 1'b1);
            6'd20: w = uw(SYM_FIVE, 1'b1);
            6'd24: w = uw(SYM_FIVE, 1'b0);
            6'd25: w = uw(SYM_ONE,  1'b1);
            6'd28: w = uw(SYM_FIVE, 1'b0);
            6'd29: w = uw(SYM_ONE,  1'b0);
            6'd30: w = uw(SYM_ONE,  1'b1);
            6'd32: w = uw(SYM_FIVE, 1'b0);
            6'd33: w = uw(SYM_ONE,  1'b0);
            6'd34: w = uw(SYM_ONE,  1'b0);
            6'd35: w = uw(SYM_ONE,  1'b1);
            6'd36: w = uw(SYM_ONE,  1'b0);
            6'd37: w = uw(SYM_TEN,  1'b1);
            default: w = uw(SYM_NONE, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of(input logic [PLACE_W-1:0] p,
                                                      input t_sym s);
        logic [LETTER_W-1:0] ch;
        ch = CH_NONE;
        unique case (p)
            PL_UNITS:     ch = (s == SYM_ONE) ? CH_I : (s == SYM_FIVE) ? CH_V : CH_X;
            PL_TENS:      ch = (s == SYM_ONE) ? CH_X : (s == SYM_FIVE) ? CH_L : CH_C;
            PL_HUNDREDS:  ch = (s == SYM_ONE) ? CH_C : (s == SYM_FIVE) ? CH_D : CH_M;
            PL_THOUSANDS: ch = CH_M;
            default:      ch = CH_NONE;
        endcase
        return ch;
    endfunction

    // k times the weight of place p
    function automatic logic [WIDE_W-1:0] place_step(input logic [PLACE_W-1:0] p,
                                                     input logic [DIGIT_W-1:0] k);
        logic [WIDE_W-1:0] base;
        base = 14'd1;
        unique case (p)
            PL_THOUSANDS: base = 14'd1000;
            PL_HUNDREDS:  base = 14'd100;
            PL_TENS:      base = 14'd10;
            default:      base = 14'd1;
        endcase
        return WIDE_W'(base * {{(WIDE_W-DIGIT_W){1'b0}}, k});
    endfunction

endpackage

FILE: sv/binary_to_roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: digit split and microcoded letter sequencer.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_value[11:0]
//  output   out        o_valid / i_stall   o_letter[7:0], o_valid_res, o_last
//
//  One beat in, then the split state takes the value apart into decimal digits by
//  parallel compare against multiples of the place weight. The sequencer then walks
//  the microcode table one step a cycle, one letter per step plus a letterless step for
//  each zero digit above the lowest nonzero one; a stalled output holds it on a letter step.
//  Zero or 4000 and up give one empty beat. A new value is taken only in idle. Reset is
//  synchronous and clears control state only.
module binary_to_roman_numeral_encoder
    import b2r_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [LETTER_W-1:0] o_letter,
    output logic                o_valid_res,
    output logic                o_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    t_state               r_state;
    logic [VALUE_W-1:0]   r_rem;
    logic [PLACE_W-1:0]   r_place;
    logic [STEP_W-1:0]    r_step;
    logic [DIGIT_W-1:0]   r_dig [4];
    logic                 r_o_valid;
    logic [LETTER_W-1:0]  r_letter;
    logic                 r_valid_res;
    logic                 r_last;

    logic [8:0]           ge;
    logic [DIGIT_W-1:0]   cnt;
    logic [VALUE_W-1:0]   n_rem;
    logic [3:0]           tail_zero;
    t_uword               word;
    logic                 out_free;
    logic                 need_out;
    logic                 out_load;
    logic                 done;
    logic                 empty_in;

    always_comb begin
        cnt = '0;
        for (int k = 1; k <= 9; k++) begin
            ge[k-1] = {{(WIDE_W-VALUE_W){1'b0}}, r_rem} >= place_step(r_place, DIGIT_W'(k));
            cnt     = cnt + DIGIT_W'(ge[k-1]);
        end
        n_rem = VALUE_W'({{(WIDE_W-VALUE_W){1'b0}}, r_rem} - place_step(r_place, cnt));
    end

    always_comb begin
        tail_zero[0] = 1'b1;
        tail_zero[1] = (r_dig[0] == '0);
        tail_zero[2] = tail_zero[1] && (r_dig[1] == '0);
        tail_zero[3] = tail_zero[2] && (r_dig[2] == '0);
    end

    assign word     = ucode_rom({r_dig[r_place], r_step});
    assign out_free = !r_o_valid || !i_stall;
    assign need_out = (word.sym != SYM_NONE);
    assign out_load = ((r_state == ST_EMIT) && need_out && out_free) ||
                      ((r_state == ST_EMPTY) && out_free);
    assign done     = word.fin && tail_zero[r_place];
    assign empty_in = (i_value == '0) || ({2'b00, i_value} >= WIDE_W'(LIMIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_place   <= PL_THOUSANDS;
            r_step    <= '0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_rem   <= i_value;
                        r_place <= PL_THOUSANDS;
                        r_step  <= '0;
                        r_state <= empty_in ? ST_EMPTY : ST_SPLIT;
                    end
                end
                ST_SPLIT: begin
                    r_dig[r_place] <= cnt;
                    r_rem          <= n_rem;
                    if (r_place == PL_TENS) begin
                        r_dig[PL_UNITS] <= n_rem[DIGIT_W-1:0];
                        r_place         <= PL_THOUSANDS;
                        r_state         <= ST_EMIT;
                    end else begin
                        r_place <= r_place - 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (!need_out || out_free) begin
                        if (need_out) begin
                            r_letter    <= letter_of(r_place, word.sym);
                            r_valid_res <= 1'b1;
                            r_last      <= done;
                        end
                        if (word.fin) begin
                            r_step <= '0;
                            if (done) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_place <= r_place - 1'b1;
                            end
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        r_letter    <= CH_NONE;
                        r_valid_res <= 1'b0;
                        r_last      <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_letter    = r_letter;
    assign o_valid_res = r_valid_res;
    assign o_last      = r_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_last && o_letter == CH_NONE))
        else $error("empty beat without last");

    a_real_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |->
            (o_letter == CH_I || o_letter == CH_V || o_letter == CH_X ||
             o_letter == CH_L || o_letter == CH_C || o_letter == CH_D ||
             o_letter == CH_M))
        else $error("bad numeral letter");

    a_digits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |->
            (r_dig[3] <= 4'd3 && r_dig[2] <= 4'd9 && r_dig[1] <= 4'd9 &&
             r_dig[0] <= 4'd9))
        else $error("digit split out of range");

endmodule
